/* rtl/dlp_pkg.sv */
// Shared types and constants for the descriptor loop parser.
package dlp_pkg;

  localparam logic [7:0] HdrNibbleMask = 8'h0F;

  typedef enum logic [2:0] {
    PH_OUTSIDE = 3'd0,
    PH_HDR_LO  = 3'd1,
    PH_TAG     = 3'd2,
    PH_LEN     = 3'd3,
    PH_BODY    = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HDR_HI = 3'd0,
    ROLE_HDR_LO = 3'd1,
    ROLE_TAG    = 3'd2,
    ROLE_LEN    = 3'd3,
    ROLE_BODY   = 3'd4,
    ROLE_OUT    = 3'd5
  } role_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERRUN   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    role_e       byte_role;
    logic [7:0]  current_tag;
    logic [7:0]  current_length;
    logic [7:0]  body_offset;
    logic [7:0]  byte_value;
    logic [11:0] loop_length;
    logic        end_of_descriptor;
    logic        end_of_loop;
    status_e     status;
  } result_t;

endpackage

/* rtl/dlp_in_reg.sv */
// Input register stage: captures one byte transaction at a time.
module dlp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       loop_start_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       loop_start_o
);
  logic       valid_q;
  logic [7:0] data_q;
  logic       start_q;
  logic       ready;

  // The stage is free when empty or when its content moves on this cycle.
  assign ready      = !valid_q || advance_i;
  assign in_stall_o = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      data_q  <= data_byte_i;
      start_q <= loop_start_i;
    end
  end

  assign valid_o      = valid_q;
  assign data_byte_o  = data_q;
  assign loop_start_o = start_q;
endmodule

/* rtl/dlp_parse.sv */
// Parse state and the per-byte classification logic.
module dlp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             loop_start_i,
  output dlp_pkg::result_t res_o
);
  import dlp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [11:0] left_q, left_d;
  logic [11:0] total_q, total_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;
  logic [3:0]  nib_q, nib_d;
  logic [11:0] left_dec;
  logic [7:0]  count_inc;
  result_t     res;

  assign left_dec  = left_q - 12'd1;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    total_d = total_q;
    tag_d   = tag_q;
    len_d   = len_q;
    count_d = count_q;
    nib_d   = nib_q;
    res     = '0;
    res.byte_role  = ROLE_OUT;
    res.status     = ST_OK;
    res.byte_value = data_byte_i;
    if (loop_start_i) begin
      if (phase_q == PH_HDR_LO || phase_q == PH_TAG || phase_q == PH_LEN ||
          phase_q == PH_BODY) begin
        res.status = ST_TRUNCATED;
      end
      nib_d   = 4'(data_byte_i & HdrNibbleMask);
      tag_d   = '0;
      len_d   = '0;
      count_d = '0;
      left_d  = '0;
      total_d = '0;
      phase_d = PH_HDR_LO;
      res.byte_role = ROLE_HDR_HI;
    end else begin
      case (phase_q)
        PH_HDR_LO: begin
          total_d = {nib_q, data_byte_i};
          left_d  = {nib_q, data_byte_i};
          res.byte_role   = ROLE_HDR_LO;
          res.loop_length = {nib_q, data_byte_i};
          if ({nib_q, data_byte_i} == 12'd0) begin
            res.end_of_loop = 1'b1;
            phase_d = PH_OUTSIDE;
          end else begin
            phase_d = PH_TAG;
          end
        end
        PH_TAG: begin
          tag_d  = data_byte_i;
          left_d = left_dec;
          res.byte_role   = ROLE_TAG;
          res.current_tag = data_byte_i;
          res.loop_length = total_q;
          // A tag that uses up the loop has no room for its length byte.
          if (left_dec == 12'd0) begin
            res.status = ST_OVERRUN;
            phase_d = PH_IGNORE;
          end else begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d   = data_byte_i;
          left_d  = left_dec;
          count_d = '0;
          res.byte_role      = ROLE_LEN;
          res.current_tag    = tag_q;
          res.current_length = data_byte_i;
          res.loop_length    = total_q;
          if ({4'd0, data_byte_i} > left_dec) begin
            res.status = ST_OVERRUN;
            phase_d = PH_IGNORE;
          end else if (data_byte_i == 8'd0) begin
            res.end_of_descriptor = 1'b1;
            if (left_dec == 12'd0) begin
              res.end_of_loop = 1'b1;
              phase_d = PH_OUTSIDE;
            end else begin
              phase_d = PH_TAG;
            end
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          left_d  = left_dec;
          count_d = count_inc;
          res.byte_role      = ROLE_BODY;
          res.current_tag    = tag_q;
          res.current_length = len_q;
          res.body_offset    = count_q;
          res.loop_length    = total_q;
          if (count_inc == len_q) begin
            res.end_of_descriptor = 1'b1;
            if (left_dec == 12'd0) begin
              res.end_of_loop = 1'b1;
              phase_d = PH_OUTSIDE;
            end else begin
              phase_d = PH_TAG;
            end
          end
        end
        default: begin
          res.byte_role = ROLE_OUT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OUTSIDE;
      left_q  <= '0;
      total_q <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      count_q <= '0;
      nib_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      total_q <= total_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      count_q <= count_d;
      nib_q   <= nib_d;
    end
  end

  assign res_o = res;

  a_start_opens_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && loop_start_i |=> phase_q == PH_HDR_LO)
    else $error("start transaction did not open a loop header");

  a_body_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> len_q != 8'd0 && count_q < len_q)
    else $error("body phase with an exhausted or empty descriptor");

  a_body_fits_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> left_q != 12'd0)
    else $error("body phase with no loop bytes left");

  a_eol_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.end_of_loop |-> res.status == ST_OK && phase_d == PH_OUTSIDE)
    else $error("loop end flagged with an error or without closing the loop");
endmodule

/* rtl/dlp_out_reg.sv */
// Result register: holds one finished result until the consumer takes it.
module dlp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dlp_pkg::result_t res_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dlp_pkg::result_t res_o
);
  import dlp_pkg::*;

  logic    valid_q;
  result_t res_q;
  logic    ready;

  assign ready     = !valid_q || !out_stall_i;
  assign advance_o = ready && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
endmodule

/* rtl/descriptor_loop_parser.sv */
// Top level of the descriptor loop parser.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   data_byte_i, loop_start_i
//   output   out        out_valid_o / out_stall_i byte_role_o ... status_o
//
// One byte per cycle sustained while the output does not stall. A byte accepted
// into the input register is labeled and written into the result register once
// that register can take it, so its result passes through both registers.
// The parse state advances as a byte moves from the input register into the
// result register, so the loop state update sets the byte rate.
// Reset empties both registers and returns the parser to outside any loop.
// A stall on the output holds the result and keeps the input register from
// draining: in_stall_o rises in that same cycle when the input register holds
// a byte, and an empty input register first takes one more byte.
module descriptor_loop_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        loop_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  current_tag_o,
  output logic [7:0]  current_length_o,
  output logic [7:0]  body_offset_o,
  output logic [7:0]  byte_value_o,
  output logic [11:0] loop_length_o,
  output logic        end_of_descriptor_o,
  output logic        end_of_loop_o,
  output logic [1:0]  status_o
);
  import dlp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_start;
  logic       advance;
  result_t    res_comb;
  result_t    res_q;

  dlp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .loop_start_i (loop_start_i),
    .advance_i    (advance),
    .valid_o      (s1_valid),
    .data_byte_o  (s1_data),
    .loop_start_o (s1_start)
  );

  dlp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (s1_data),
    .loop_start_i (s1_start),
    .res_o        (res_comb)
  );

  dlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .res_i       (res_comb),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign byte_role_o         = res_q.byte_role;
  assign current_tag_o       = res_q.current_tag;
  assign current_length_o    = res_q.current_length;
  assign body_offset_o       = res_q.body_offset;
  assign byte_value_o        = res_q.byte_value;
  assign loop_length_o       = res_q.loop_length;
  assign end_of_descriptor_o = res_q.end_of_descriptor;
  assign end_of_loop_o       = res_q.end_of_loop;
  assign status_o            = res_q.status;
endmodule

/* verif/descriptor_loop_parser_test.sv */
// Self-checking testbench for the descriptor loop parser, with a predictor, driver and monitor.
`timescale 1ns / 1ps

module descriptor_loop_parser_test;
  import dlp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam int BytesPerPhase = 340;
  localparam int HoldOffCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        loop_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  byte_role_o;
  logic [7:0]  current_tag_o;
  logic [7:0]  current_length_o;
  logic [7:0]  body_offset_o;
  logic [7:0]  byte_value_o;
  logic [11:0] loop_length_o;
  logic        end_of_descriptor_o;
  logic        end_of_loop_o;
  logic [1:0]  status_o;

  descriptor_loop_parser i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .loop_start_i,
    .out_valid_o,
    .out_stall_i,
    .byte_role_o,
    .current_tag_o,
    .current_length_o,
    .body_offset_o,
    .byte_value_o,
    .loop_length_o,
    .end_of_descriptor_o,
    .end_of_loop_o,
    .status_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stream_byte_t stream_q [$];
  result_t      labels_q [$];
  idle_mode_e   pace = IDLE_NONE;
  logic         hold_off = 1'b0;
  logic         squeeze_go = 1'b0;
  logic         offer_taken = 1'b0;
  stream_byte_t offer;
  result_t      predicted;
  result_t      want;
  result_t      got;
  int           errors = 0;
  int           checked = 0;
  int           loop_starts = 0;
  int           overruns = 0;
  int           truncations = 0;
  int           loops_closed = 0;

  // Parser state mirrored by the predictor.
  phase_e      ph_q = PH_OUTSIDE;
  logic [11:0] left_q = '0;
  logic [11:0] total_q = '0;
  logic [7:0]  tag_q = '0;
  logic [7:0]  len_q = '0;
  logic [7:0]  count_q = '0;
  logic [3:0]  nibble_q = '0;

  function automatic void close_descriptor(inout result_t r);
    if (left_q == 12'd0) begin
      r.end_of_loop = 1'b1;
      ph_q = PH_OUTSIDE;
    end else begin
      ph_q = PH_TAG;
    end
  endfunction

  // Labels one stream byte and advances the mirrored parser state.
  function automatic result_t label_byte(input logic [7:0] b, input logic s);
    result_t r;
    r = '0;
    r.byte_role = ROLE_OUT;
    r.status = ST_OK;
    r.byte_value = b;
    if (s) begin
      if (ph_q != PH_OUTSIDE && ph_q != PH_IGNORE) r.status = ST_TRUNCATED;
      nibble_q = b[3:0];
      tag_q = '0;
      len_q = '0;
      count_q = '0;
      left_q = '0;
      total_q = '0;
      ph_q = PH_HDR_LO;
      r.byte_role = ROLE_HDR_HI;
    end else begin
      case (ph_q)
        PH_HDR_LO: begin
          total_q = {nibble_q, b};
          left_q = total_q;
          r.byte_role = ROLE_HDR_LO;
          r.loop_length = total_q;
          if (total_q == 12'd0) begin
            r.end_of_loop = 1'b1;
            ph_q = PH_OUTSIDE;
          end else begin
            ph_q = PH_TAG;
          end
        end
        PH_TAG: begin
          tag_q = b;
          left_q = left_q - 12'd1;
          r.byte_role = ROLE_TAG;
          r.current_tag = b;
          r.loop_length = total_q;
          if (left_q == 12'd0) begin
            r.status = ST_OVERRUN;
            ph_q = PH_IGNORE;
          end else begin
            ph_q = PH_LEN;
          end
        end
        PH_LEN: begin
          len_q = b;
          left_q = left_q - 12'd1;
          r.byte_role = ROLE_LEN;
          r.current_tag = tag_q;
          r.current_length = b;
          r.loop_length = total_q;
          count_q = '0;
          if ({4'h0, b} > left_q) begin
            r.status = ST_OVERRUN;
            ph_q = PH_IGNORE;
          end else if (b == 8'd0) begin
            r.end_of_descriptor = 1'b1;
            close_descriptor(r);
          end else begin
            ph_q = PH_BODY;
          end
        end
        PH_BODY: begin
          r.byte_role = ROLE_BODY;
          r.current_tag = tag_q;
          r.current_length = len_q;
          r.body_offset = count_q;
          r.loop_length = total_q;
          left_q = left_q - 12'd1;
          count_q = count_q + 8'd1;
          if (count_q == len_q) begin
            r.end_of_descriptor = 1'b1;
            close_descriptor(r);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [11:0] exp_v,
                            input logic [11:0] act_v);
    $display("ERROR at %0t: %s expected %0h, got %0h", $time, what, exp_v, act_v);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    stream_byte_t e;
    e.data = b;
    e.start = s;
    stream_q = {stream_q, e};
  endtask

  // Mostly well-formed loops with random content; the rest are broken loops and noise.
  task automatic add_stream_unit();
    int k;
    int blen;
    int declared;
    int keep;
    logic [11:0] dl;
    logic [3:0] junk;
    logic [7:0] body [$];
    k = int'($urandom_range(99));
    if (k >= 85) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(7) == 0);
    end else begin
      repeat ($urandom_range(4)) begin
        blen = ($urandom_range(59) == 0) ? int'($urandom_range(200, 255)) :
                                           int'($urandom_range(6));
        body = {body, 8'($urandom)};
        body = {body, 8'(blen)};
        repeat (blen) body = {body, 8'($urandom)};
      end
      declared = body.size();
      keep = body.size();
      if (k >= 70) begin
        case ($urandom_range(2))
          0: declared = (declared > 3) ? declared - int'($urandom_range(1, 3)) : 0;
          1: declared = declared + int'($urandom_range(1, 3));
          default: keep = int'($urandom_range(body.size()));
        endcase
      end
      dl = 12'(declared);
      junk = 4'($urandom);
      push_byte({junk, dl[11:8]}, 1'b1);
      push_byte(dl[7:0], 1'b0);
      for (int i = 0; i < keep; i++) push_byte(body[i], 1'b0);
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // Input side: a transaction is taken at a rising edge with valid high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = label_byte(data_byte_i, loop_start_i);
      labels_q = {labels_q, predicted};
      offer_taken = 1'b1;
      if (loop_start_i) loop_starts++;
      if (predicted.status == ST_OVERRUN) overruns++;
      if (predicted.status == ST_TRUNCATED) truncations++;
      if (predicted.end_of_loop) loops_closed++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || offer_taken) begin
        offer_taken = 1'b0;
        if (stream_q.size() != 0 &&
            !(pace == IDLE_SEND && $urandom_range(99) < 88) &&
            !(pace == IDLE_BOTH && $urandom_range(99) < 25)) begin
          offer = stream_q.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= offer.data;
          loop_start_i <= offer.start;
        end else begin
          in_valid_i <= 1'b0;
          data_byte_i <= 8'($urandom);
          loop_start_i <= 1'($urandom);
        end
      end
      out_stall_i <= hold_off ||
                     (pace == IDLE_RECV && $urandom_range(99) < 88) ||
                     (pace == IDLE_BOTH && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (labels_q.size() == 0) begin
        flag_error("result with no byte pending, byte_value", 12'h0, 12'(byte_value_o));
      end else begin
        want = labels_q.pop_front();
        got.byte_role = role_e'(byte_role_o);
        got.current_tag = current_tag_o;
        got.current_length = current_length_o;
        got.body_offset = body_offset_o;
        got.byte_value = byte_value_o;
        got.loop_length = loop_length_o;
        got.end_of_descriptor = end_of_descriptor_o;
        got.end_of_loop = end_of_loop_o;
        got.status = status_e'(status_o);
        checked++;
        if (got.byte_role !== want.byte_role)
          flag_error("byte_role", 12'(want.byte_role), 12'(got.byte_role));
        if (got.current_tag !== want.current_tag)
          flag_error("current_tag", 12'(want.current_tag), 12'(got.current_tag));
        if (got.current_length !== want.current_length)
          flag_error("current_length", 12'(want.current_length),
                     12'(got.current_length));
        if (got.body_offset !== want.body_offset)
          flag_error("body_offset", 12'(want.body_offset), 12'(got.body_offset));
        if (got.byte_value !== want.byte_value)
          flag_error("byte_value", 12'(want.byte_value), 12'(got.byte_value));
        if (got.loop_length !== want.loop_length)
          flag_error("loop_length", want.loop_length, got.loop_length);
        if (got.end_of_descriptor !== want.end_of_descriptor)
          flag_error("end_of_descriptor", 12'(want.end_of_descriptor),
                     12'(got.end_of_descriptor));
        if (got.end_of_loop !== want.end_of_loop)
          flag_error("end_of_loop", 12'(want.end_of_loop), 12'(got.end_of_loop));
        if (got.status !== want.status)
          flag_error("status", 12'(want.status), 12'(got.status));
      end
    end
  end

  // Long output hold-off while bytes keep coming, so the input side backs up.
  initial begin
    wait (squeeze_go);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #1000000;
    $display("descriptor_loop_parser_test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 4; p++) begin
      pace = idle_mode_e'(p);
      if (pace == IDLE_NONE) begin
        push_byte(8'h3C, 1'b0);  // byte before any loop
        push_byte(8'hF0, 1'b1);  // zero-length loop, junk in the upper nibble
        push_byte(8'h00, 1'b0);
        push_byte(8'hAF, 1'b1);  // longest loop, cut short inside a body
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);  // start while a body is open
        push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);  // empty descriptor ends the loop
        push_byte(8'h00, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h48, 1'b0);  // tag byte is the last loop byte
        push_byte(8'h00, 1'b1);  // start while ignoring is not a truncation
        push_byte(8'h03, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h05, 1'b0);  // descriptor longer than the loop
        push_byte(8'h01, 1'b1);
        push_byte(8'h10, 1'b1);  // start while the header low byte is due
        push_byte(8'h03, 1'b0);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hAA, 1'b0);
        squeeze_go = 1'b1;
      end
      while (stream_q.size() < BytesPerPhase) add_stream_unit();
      while (stream_q.size() != 0 || in_valid_i || labels_q.size() != 0) @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    $display("Checked %0d labeled bytes across %0d loop starts under four pacing modes.",
             checked, loop_starts);
    $display("Saw %0d closed loops, %0d overruns and %0d truncated loops.",
             loops_closed, overruns, truncations);
    if (errors == 0 && labels_q.size() == 0) begin
      $display("descriptor_loop_parser_test passed");
    end else begin
      $display("descriptor_loop_parser_test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dlp_pkg.sv
rtl/dlp_in_reg.sv
rtl/dlp_parse.sv
rtl/dlp_out_reg.sv
rtl/descriptor_loop_parser.sv
verif/descriptor_loop_parser_test.sv
